FILE: design/button_debounce_click_classifier_assert.svh
// Assertion macros shared by the button click classifier.
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define BDC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/bdc_pkg.sv
`default_nettype none

package bdc_pkg;

	// Width of every per-button field on the streams.
	localparam int FIELD_W = 3;

	// Stream data widths, rounded up to whole bytes.
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// Configuration port geometry.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_REG_W  = 16;

	// Register word indexes (paddr[3:2]).
	localparam logic [1:0] REG_PRESSED_LEVEL = 2'd0;
	localparam logic [1:0] REG_HOLD_TICKS    = 2'd1;
	localparam logic [1:0] REG_CLICK_WINDOW  = 2'd2;

	// Register reset values.
	localparam logic [CFG_REG_W-1:0] HOLD_TICKS_RESET   = 16'd100;
	localparam logic [CFG_REG_W-1:0] CLICK_WINDOW_RESET = 16'd30;

	// The four sticky flags of one button; also used for the acknowledge bits.
	typedef struct packed {
		logic single_f;
		logic double_f;
		logic long_f;
		logic release_f;
	} bdc_flags_t;

endpackage

`default_nettype wire

FILE: design/bdc_lane.sv
`default_nettype none

// One button: three-sample debouncer, click counter and hold timer.
module bdc_lane #(
	parameter int TIMER_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic                   raw,
	input  wire logic                   pressed_level,
	input  wire logic [TIMER_BITS-1:0]  hold_load,
	input  wire logic [TIMER_BITS-1:0]  half_load,
	input  wire logic [TIMER_BITS-1:0]  win_load,
	input  wire bdc_pkg::bdc_flags_t    ack,
	output bdc_pkg::bdc_flags_t         flags_next
);

	// After the shift the oldest sample is the current middle one, so two
	// registered samples plus the incoming level form the three-sample window.
	logic                  middle_q, newest_q, stable_q;
	logic [TIMER_BITS-1:0] hold_q, click_q;
	logic                  seen_q;
	bdc_pkg::bdc_flags_t   flags_q;

	logic                  stable_n;
	logic [TIMER_BITS-1:0] hold_n, click_n, hold_dec, click_dec;
	logic                  seen_n;
	logic                  agree;

	// Next state of the button for the current tick.
	always_comb begin
		flags_next.single_f  = flags_q.single_f  & ~ack.single_f;
		flags_next.double_f  = flags_q.double_f  & ~ack.double_f;
		flags_next.long_f    = flags_q.long_f    & ~ack.long_f;
		flags_next.release_f = flags_q.release_f & ~ack.release_f;
		stable_n  = stable_q;
		hold_n    = hold_q;
		click_n   = click_q;
		seen_n    = seen_q;
		hold_dec  = hold_q - TIMER_BITS'(1);
		click_dec = '0;
		agree     = (middle_q == newest_q) && (newest_q == raw);

		if (agree) begin
			// Change of the debounced level, with click counting on release.
			if (stable_q != raw) begin
				if (stable_q == pressed_level) begin
					flags_next.release_f = 1'b1;
					if (!seen_q) begin
						seen_n  = 1'b1;
						click_n = win_load;
					end else begin
						flags_next.double_f = 1'b1;
						seen_n  = 1'b0;
						click_n = '0;
					end
				end
				stable_n = raw;
				if (raw == pressed_level) begin
					hold_n = hold_load;
				end
			end else if (raw == pressed_level && hold_q != '0) begin
				// Held: count down to the long-press flag, then repeat at half period.
				if (hold_dec == '0) begin
					flags_next.long_f = 1'b1;
					hold_n = half_load;
				end else begin
					hold_n = hold_dec;
				end
			end

			// Click window countdown; expiry after one click is a single click.
			click_dec = click_n - TIMER_BITS'(1);
			if (click_n != '0) begin
				click_n = click_dec;
				if (click_dec == '0) begin
					if (seen_n) begin
						flags_next.single_f = 1'b1;
					end
					seen_n = 1'b0;
				end
			end
		end
	end

	// Button state registers; samples reset to the normal (released) level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			middle_q <= 1'b1;
			newest_q <= 1'b1;
			stable_q <= 1'b1;
			hold_q   <= '0;
			click_q  <= '0;
			seen_q   <= 1'b0;
			flags_q  <= '0;
		end else if (advance) begin
			middle_q <= newest_q;
			newest_q <= raw;
			stable_q <= stable_n;
			hold_q   <= hold_n;
			click_q  <= click_n;
			seen_q   <= seen_n;
			flags_q  <= flags_next;
		end
	end

endmodule

`default_nettype wire

FILE: design/bdc_merge.sv
`default_nettype none

// Gathers the lane flags into the result fields and holds them in an
// output register backed by a skid register.
module bdc_merge #(
	parameter int NUM_BUTTONS = 3
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               advance,
	input  wire bdc_pkg::bdc_flags_t                lane_flags [NUM_BUTTONS],
	output logic                                    in_ready,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [bdc_pkg::OUT_TDATA_W-1:0]         out_data,
	output logic                                    skid_valid
);

	localparam int FW = bdc_pkg::FIELD_W;

	logic [FW-1:0] single_v, double_v, long_v, release_v;
	logic [bdc_pkg::OUT_TDATA_W-1:0] result;
	logic [bdc_pkg::OUT_TDATA_W-1:0] out_q, skid_q;
	logic out_v_q, skid_v_q;

	// Per-field bit gather; bits above the button count stay zero.
	for (genvar i = 0; i < FW; i++) begin : g_bits
		if (i < NUM_BUTTONS) begin : g_lane
			assign single_v[i]  = lane_flags[i].single_f;
			assign double_v[i]  = lane_flags[i].double_f;
			assign long_v[i]    = lane_flags[i].long_f;
			assign release_v[i] = lane_flags[i].release_f;
		end else begin : g_none
			assign single_v[i]  = 1'b0;
			assign double_v[i]  = 1'b0;
			assign long_v[i]    = 1'b0;
			assign release_v[i] = 1'b0;
		end
	end

	assign result = {{(bdc_pkg::OUT_TDATA_W - 4*FW){1'b0}},
		release_v, long_v, double_v, single_v};

	// Output register with skid: a new request is taken unless the skid is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q | advance;
			skid_v_q <= 1'b0;
		end else if (advance) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : result;
		end else if (advance) begin
			skid_q <= result;
		end
	end

	assign in_ready   = !skid_v_q;
	assign out_valid  = out_v_q;
	assign out_data   = out_q;
	assign skid_valid = skid_v_q;

endmodule

`default_nettype wire

FILE: design/button_debounce_click_classifier.sv
// Channel   | Direction | Payload (lowest bits first)
// s_axis    | in        | raw_levels, ack_single_mask, ack_double_mask,
//           |           | ack_long_mask, ack_release_mask (3 bits each)
// m_axis    | out       | single_click_pending, double_click_pending,
//           |           | long_press_pending, release_pending (3 bits each)
// apb       | cfg       | pressed_level @0x0, hold_ticks @0x4, click_window_ticks @0x8
//
// One tick request per cycle while s_tready is high; every button lane updates in the accepting cycle.
// The result is registered in the output register, or in the skid register while the output stalls.
// A skid register keeps input ready for one more request while m_tready is low.
// Reset is asynchronous; no clearing pass is needed.
`default_nettype none

`include "button_debounce_click_classifier_assert.svh"

module button_debounce_click_classifier #(
	parameter int NUM_BUTTONS = 3,
	parameter int TIMER_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// APB configuration port.
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [bdc_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire logic [bdc_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [bdc_pkg::CFG_DATA_W-1:0]           prdata,
	output logic                                     pready,
	// Tick input stream.
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [2:0] raw_levels, [5:3] ack_single_mask, [8:6] ack_double_mask,
	// [11:9] ack_long_mask, [14:12] ack_release_mask, [15] zero
	input  wire logic [bdc_pkg::IN_TDATA_W-1:0]      s_tdata,
	// Result stream.
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [2:0] single_click_pending, [5:3] double_click_pending,
	// [8:6] long_press_pending, [11:9] release_pending, [15:12] zero
	output logic [bdc_pkg::OUT_TDATA_W-1:0]          m_tdata
);

	localparam int FW = bdc_pkg::FIELD_W;

	logic                           pressed_q;
	logic [bdc_pkg::CFG_REG_W-1:0]  hold_q, window_q;
	logic                           cfg_wr;
	logic [1:0]                     reg_idx;
	logic                           s_acc;
	logic                           skid_valid;
	logic [TIMER_BITS-1:0]          hold_load, half_load, win_load;

	logic [FW-1:0] raw_levels, ack_single, ack_double, ack_long, ack_release;
	bdc_pkg::bdc_flags_t lane_flags [NUM_BUTTONS];

	// Configuration registers.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			hold_q    <= bdc_pkg::HOLD_TICKS_RESET;
			window_q  <= bdc_pkg::CLICK_WINDOW_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bdc_pkg::REG_PRESSED_LEVEL: pressed_q <= pwdata[0];
				bdc_pkg::REG_HOLD_TICKS:    hold_q    <= pwdata[bdc_pkg::CFG_REG_W-1:0];
				bdc_pkg::REG_CLICK_WINDOW:  window_q  <= pwdata[bdc_pkg::CFG_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			bdc_pkg::REG_PRESSED_LEVEL: prdata = {{(bdc_pkg::CFG_DATA_W-1){1'b0}}, pressed_q};
			bdc_pkg::REG_HOLD_TICKS:
				prdata = {{(bdc_pkg::CFG_DATA_W-bdc_pkg::CFG_REG_W){1'b0}}, hold_q};
			bdc_pkg::REG_CLICK_WINDOW:
				prdata = {{(bdc_pkg::CFG_DATA_W-bdc_pkg::CFG_REG_W){1'b0}}, window_q};
			default: prdata = '0;
		endcase
	end

	// Timer load values, fitted to the timer width.
	assign hold_load = TIMER_BITS'(hold_q);
	assign half_load = TIMER_BITS'(hold_q >> 1);
	assign win_load  = TIMER_BITS'(window_q);

	// Input field unpacking.
	assign raw_levels  = s_tdata[FW-1:0];
	assign ack_single  = s_tdata[2*FW-1:FW];
	assign ack_double  = s_tdata[3*FW-1:2*FW];
	assign ack_long    = s_tdata[4*FW-1:3*FW];
	assign ack_release = s_tdata[5*FW-1:4*FW];

	assign s_acc = s_tvalid & s_tready;

	// Button lanes; lanes above the field width see a low raw level and no acknowledges.
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic                raw_i;
		bdc_pkg::bdc_flags_t ack_i;

		if (i < FW) begin : g_in
			assign raw_i           = raw_levels[i];
			assign ack_i.single_f  = ack_single[i];
			assign ack_i.double_f  = ack_double[i];
			assign ack_i.long_f    = ack_long[i];
			assign ack_i.release_f = ack_release[i];
		end else begin : g_zero
			assign raw_i = 1'b0;
			assign ack_i = '0;
		end

		bdc_lane #(
			.TIMER_BITS(TIMER_BITS)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (s_acc),
			.raw          (raw_i),
			.pressed_level(pressed_q),
			.hold_load    (hold_load),
			.half_load    (half_load),
			.win_load     (win_load),
			.ack          (ack_i),
			.flags_next   (lane_flags[i])
		);
	end

	// Result gathering and output buffering.
	bdc_merge #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (s_acc),
		.lane_flags(lane_flags),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.skid_valid(skid_valid)
	);

	// A filled skid register implies a result is waiting at the output.
	`BDC_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_valid, m_tvalid)
	// A request taken while the output stalls lands in the skid register.
	`BDC_ASSERT_NXT(a_stall_to_skid, clk, arst_n, s_acc && m_tvalid && !m_tready, skid_valid)
	// Every accepted request leaves a valid result at the output on the next cycle.
	`BDC_ASSERT_NXT(a_acc_gives_out, clk, arst_n, s_acc, m_tvalid)

endmodule

`default_nettype wire
